// File: src/pgp_pkg.sv
// ----------------------------------------------------------------------------
// pgp_pkg
// Shared constants, types and the CORDIC arctangent table of the pixel to
// ground projection pipeline.
// ----------------------------------------------------------------------------
package pgp_pkg;

  // Angle format of the pitch and yaw registers (fraction bits of a radian).
  localparam int ANGLE_FRAC_BITS = 13;
  // Number of CORDIC micro-rotations, one pipeline stage each.
  localparam int CORDIC_STAGES = 16;

  // Divider: quotient bits, dividend magnitude bits, divisor bits.
  localparam int QW = 30;
  localparam int NW = 46;
  localparam int DW = 34;
  localparam int DIV_LAT = QW + 1;

  // Vectoring CORDIC datapath and angle accumulator widths.
  localparam int AW = 48;
  localparam int ZW = 34;
  // Angle sum width: a 16 bit register scaled to Q30 plus the arctangent.
  localparam int ANW = 16 + (30 - ANGLE_FRAC_BITS) + 3;
  // Rotation CORDIC datapath width and width of the scaled cosine and sine.
  localparam int RW = 32;
  localparam int CSW = 18;

  // Angle constants in Q30 radians.
  localparam logic signed [ANW-1:0] PI_Q30      = ANW'(64'sd3373259426);
  localparam logic signed [ANW-1:0] HALF_PI_Q30 = ANW'(64'sd1686629713);
  localparam logic signed [ANW-1:0] TWO_PI_Q30  = ANW'(64'sd6746518852);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_TAN_FOV_W     = 3'd2,
    REG_TAN_FOV_H     = 3'd3,
    REG_CAMERA_HEIGHT = 3'd4,
    REG_CAMERA_PITCH  = 3'd5,
    REG_CAMERA_YAW    = 3'd6
  } cfg_reg_t;

  // Result of one division: quotient magnitude, overflow and sign.
  typedef struct packed {
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } div_res_t;

  // atan(2^-i) in Q30, truncated.
  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: src/pgp_div.sv
// ----------------------------------------------------------------------------
// pgp_div
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per
// stage, with an overflow flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module pgp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      iv,
  input  logic [pgp_pkg::NW-1:0]    num,
  input  logic [pgp_pkg::DW-1:0]    den,
  input  logic                      neg,
  output logic                      ov,
  output pgp_pkg::div_res_t         res
);

  localparam int QW = pgp_pkg::QW;
  localparam int NW = pgp_pkg::NW;
  localparam int DW = pgp_pkg::DW;
  localparam int XW = DW + QW;

  logic [XW-1:0] rem [0:QW];
  logic [QW-1:0] quo [0:QW];
  logic [DW-1:0] dv  [0:QW];
  logic          ng  [0:QW];
  logic          of  [0:QW];
  logic          vl  [0:QW];

  // Input stage: capture operands and flag a quotient of more than QW bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= iv;
    end
    if (en) begin
      rem[0] <= XW'(num);
      quo[0] <= '0;
      dv[0]  <= den;
      ng[0]  <= neg;
      of[0]  <= (num >> QW) >= NW'(den);
    end
  end

  // One trial subtraction per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int J = QW - k;
    logic [XW-1:0] sub;
    logic [XW:0]   diff;
    assign sub  = XW'(dv[k-1]) << J;
    assign diff = {1'b0, rem[k-1]} - {1'b0, sub};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= vl[k-1];
      end
      if (en) begin
        rem[k] <= diff[XW] ? rem[k-1] : diff[XW-1:0];
        quo[k] <= {quo[k-1][QW-2:0], ~diff[XW]};
        dv[k]  <= dv[k-1];
        ng[k]  <= ng[k-1];
        of[k]  <= of[k-1];
      end
    end
  end

  assign ov      = vl[QW];
  assign res.q   = quo[QW];
  assign res.ovf = of[QW];
  assign res.neg = ng[QW];

endmodule

// File: src/pgp_atan.sv
// ----------------------------------------------------------------------------
// pgp_atan
// Pipelined vectoring CORDIC: arctangent of a signed Q16 term, in Q30
// radians, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module pgp_atan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            iv,
  input  pgp_pkg::div_res_t               term,
  output logic                            ov,
  output logic signed [pgp_pkg::ZW-1:0]   z
);

  localparam int CS = pgp_pkg::CORDIC_STAGES;
  localparam int AW = pgp_pkg::AW;
  localparam int ZW = pgp_pkg::ZW;
  localparam int QW = pgp_pkg::QW;

  logic signed [AW-1:0] xs [0:CS];
  logic signed [AW-1:0] ys [0:CS];
  logic signed [ZW-1:0] zs [0:CS];
  logic                 vl [0:CS];
  logic signed [QW:0]   t;

  // Apply the sign of the quotient to get the Q16 term.
  assign t = term.neg ? -$signed({1'b0, term.q}) : $signed({1'b0, term.q});

  // Start vector (2^30, term * 2^14).
  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= iv;
    end
    if (en) begin
      xs[0] <= $signed(AW'(1) << 30);
      ys[0] <= AW'(t) <<< 14;
      zs[0] <= '0;
    end
  end

  // Drive y toward zero and accumulate the angle.
  for (genvar k = 1; k <= CS; k++) begin : g_step
    localparam int I = k - 1;
    localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(pgp_pkg::atan_tab(I)));
    logic signed [AW-1:0] dx;
    logic signed [AW-1:0] dy;
    assign dx = ys[k-1] >>> I;
    assign dy = xs[k-1] >>> I;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= vl[k-1];
      end
      if (en) begin
        if (ys[k-1] > 0) begin
          xs[k] <= xs[k-1] + dx;
          ys[k] <= ys[k-1] - dy;
          zs[k] <= zs[k-1] + ATAN;
        end else begin
          xs[k] <= xs[k-1] - dx;
          ys[k] <= ys[k-1] + dy;
          zs[k] <= zs[k-1] - ATAN;
        end
      end
    end
  end

  assign ov = vl[CS];
  assign z  = zs[CS];

endmodule

// File: src/pgp_rot.sv
// ----------------------------------------------------------------------------
// pgp_rot
// Adds the camera angle to the arctangent, folds the sum into -pi/2..pi/2
// and runs a pipelined rotation CORDIC for scaled cosine and sine.
// ----------------------------------------------------------------------------
module pgp_rot (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             iv,
  input  logic signed [pgp_pkg::ZW-1:0]    z,
  input  logic signed [15:0]               angle,
  output logic                             ov,
  output logic signed [pgp_pkg::CSW-1:0]   c,
  output logic signed [pgp_pkg::CSW-1:0]   s
);

  localparam int CS  = pgp_pkg::CORDIC_STAGES;
  localparam int ANW = pgp_pkg::ANW;
  localparam int RW  = pgp_pkg::RW;
  localparam int CSW = pgp_pkg::CSW;
  localparam int SH  = 30 - pgp_pkg::ANGLE_FRAC_BITS;

  logic signed [ANW-1:0] a0;
  logic signed [ANW-1:0] a1;
  logic                  v0;
  logic                  v1;

  logic signed [RW-1:0]  xs [0:CS];
  logic signed [RW-1:0]  ys [0:CS];
  logic signed [ANW-1:0] as [0:CS];
  logic                  vl [0:CS];

  // Angle sum, wrap into -pi..pi, then fold by pi (same tangent).
  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      vl[0] <= 1'b0;
    end else if (en) begin
      v0    <= iv;
      v1    <= v0;
      vl[0] <= v1;
    end
    if (en) begin
      a0 <= (ANW'(angle) <<< SH) + ANW'(z);
      if (a0 >= pgp_pkg::PI_Q30) begin
        a1 <= a0 - pgp_pkg::TWO_PI_Q30;
      end else if (a0 < -pgp_pkg::PI_Q30) begin
        a1 <= a0 + pgp_pkg::TWO_PI_Q30;
      end else begin
        a1 <= a0;
      end
      if (a1 > pgp_pkg::HALF_PI_Q30) begin
        as[0] <= a1 - pgp_pkg::PI_Q30;
      end else if (a1 < -pgp_pkg::HALF_PI_Q30) begin
        as[0] <= a1 + pgp_pkg::PI_Q30;
      end else begin
        as[0] <= a1;
      end
      xs[0] <= $signed(RW'(1) << 29);
      ys[0] <= '0;
    end
  end

  // Rotate by the residual angle, one micro-rotation per stage.
  for (genvar k = 1; k <= CS; k++) begin : g_step
    localparam int I = k - 1;
    localparam logic signed [ANW-1:0] ATAN = $signed(ANW'(pgp_pkg::atan_tab(I)));
    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] dy;
    assign dx = ys[k-1] >>> I;
    assign dy = xs[k-1] >>> I;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= vl[k-1];
      end
      if (en) begin
        if (as[k-1] >= 0) begin
          xs[k] <= xs[k-1] - dx;
          ys[k] <= ys[k-1] + dy;
          as[k] <= as[k-1] - ATAN;
        end else begin
          xs[k] <= xs[k-1] + dx;
          ys[k] <= ys[k-1] - dy;
          as[k] <= as[k-1] + ATAN;
        end
      end
    end
  end

  // Scale down by 2^14, rounding toward zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= vl[CS];
    end
    if (en) begin
      c <= CSW'(xs[CS] / 32'sd16384);
      s <= CSW'(ys[CS] / 32'sd16384);
    end
  end

endmodule

// File: src/pixel_to_ground_projection.sv
// ----------------------------------------------------------------------------
// pixel_to_ground_projection
// Throughput: one transaction per cycle; the divider and CORDIC pipelines
// set the depth. A stall at the output holds the whole pipeline.
// Reset clears all valid bits and loads the configuration reset values.
// ----------------------------------------------------------------------------
module pixel_to_ground_projection (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        pixel_col,
  input  logic [11:0]        pixel_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] ground_forward,
  output logic signed [15:0] ground_lateral,
  output logic               projection_invalid
);

  localparam int NW      = pgp_pkg::NW;
  localparam int DW      = pgp_pkg::DW;
  localparam int QW      = pgp_pkg::QW;
  localparam int ZW      = pgp_pkg::ZW;
  localparam int CSW     = pgp_pkg::CSW;
  localparam int DIV_LAT = pgp_pkg::DIV_LAT;
  localparam int PW      = 13 + CSW;
  localparam int DNW     = 2 * CSW;
  localparam int NUMW    = 48;

  typedef struct packed {
    logic s1_pos;
    logic c2_zero;
    logic num_zero;
    logic num_neg;
  } flags_t;

  // Configuration registers.
  logic [12:0]        image_width;
  logic [12:0]        image_height;
  logic [15:0]        tan_fov_w;
  logic [15:0]        tan_fov_h;
  logic [11:0]        camera_height;
  logic signed [15:0] camera_pitch;
  logic signed [15:0] camera_yaw;

  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 13'd640;
      image_height  <= 13'd480;
      tan_fov_w     <= 16'd46248;
      tan_fov_h     <= 16'd26011;
      camera_height <= 12'd500;
      camera_pitch  <= '0;
      camera_yaw    <= '0;
    end else if (cfg_write) begin
      case (pgp_pkg::cfg_reg_t'(cfg_index))
        pgp_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[12:0];
        pgp_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[12:0];
        pgp_pkg::REG_TAN_FOV_W:     tan_fov_w     <= cfg_data;
        pgp_pkg::REG_TAN_FOV_H:     tan_fov_h     <= cfg_data;
        pgp_pkg::REG_CAMERA_HEIGHT: camera_height <= cfg_data[11:0];
        pgp_pkg::REG_CAMERA_PITCH:  camera_pitch  <= $signed(cfg_data);
        pgp_pkg::REG_CAMERA_YAW:    camera_yaw    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held at the output.
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  // Normalization numerators: |W - 2*col| * tan and |2*row - H| * tan.
  logic [12:0]        w_eff;
  logic [12:0]        h_eff;
  logic signed [14:0] dh;
  logic signed [14:0] dv;
  logic [13:0]        mh;
  logic [13:0]        mv;

  assign w_eff = (image_width == '0) ? 13'd1 : image_width;
  assign h_eff = (image_height == '0) ? 13'd1 : image_height;
  assign dh    = $signed({2'b00, w_eff}) - $signed({2'b00, pixel_col, 1'b0});
  assign dv    = $signed({2'b00, pixel_row, 1'b0}) - $signed({2'b00, h_eff});
  assign mh    = dh[14] ? 14'(-dh) : dh[13:0];
  assign mv    = dv[14] ? 14'(-dv) : dv[13:0];

  logic          v1;
  logic [NW-1:0] num_h;
  logic [NW-1:0] num_v;
  logic [DW-1:0] den_h;
  logic [DW-1:0] den_v;
  logic          neg_h;
  logic          neg_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      num_h <= NW'(mh * tan_fov_w);
      num_v <= NW'(mv * tan_fov_h);
      den_h <= DW'(w_eff);
      den_v <= DW'(h_eff);
      neg_h <= dh[14];
      neg_v <= dv[14];
    end
  end

  // Normalizing divisions.
  logic              vq_h;
  logic              vq_v;
  pgp_pkg::div_res_t q_h;
  pgp_pkg::div_res_t q_v;

  pgp_div u_div_h (
    .clk(clk), .rst(rst), .en(en), .iv(v1),
    .num(num_h), .den(den_h), .neg(neg_h), .ov(vq_h), .res(q_h)
  );

  pgp_div u_div_v (
    .clk(clk), .rst(rst), .en(en), .iv(v1),
    .num(num_v), .den(den_v), .neg(neg_v), .ov(vq_v), .res(q_v)
  );

  // Arctangents of the vertical and horizontal terms.
  logic                 va_v;
  logic                 va_h;
  logic signed [ZW-1:0] z_v;
  logic signed [ZW-1:0] z_h;

  pgp_atan u_atan_v (
    .clk(clk), .rst(rst), .en(en), .iv(vq_v), .term(q_v), .ov(va_v), .z(z_v)
  );

  pgp_atan u_atan_h (
    .clk(clk), .rst(rst), .en(en), .iv(vq_h), .term(q_h), .ov(va_h), .z(z_h)
  );

  // Cosine and sine of pitch and yaw sums.
  logic                  vr1;
  logic                  vr2;
  logic signed [CSW-1:0] c1;
  logic signed [CSW-1:0] s1;
  logic signed [CSW-1:0] c2;
  logic signed [CSW-1:0] s2;

  pgp_rot u_rot_pitch (
    .clk(clk), .rst(rst), .en(en), .iv(va_v), .z(z_v), .angle(camera_pitch),
    .ov(vr1), .c(c1), .s(s1)
  );

  pgp_rot u_rot_yaw (
    .clk(clk), .rst(rst), .en(en), .iv(va_h), .z(z_h), .angle(camera_yaw),
    .ov(vr2), .c(c2), .s(s2)
  );

  // Products: h*c1, s1*c2, then h*c1*s2, then magnitudes for the dividers.
  logic                  vf1;
  logic                  vf2;
  logic                  vf3;
  logic signed [PW-1:0]  p1;
  logic signed [PW-1:0]  p2;
  logic signed [DNW-1:0] den1;
  logic signed [DNW-1:0] den2;
  logic signed [CSW-1:0] s1_f1;
  logic signed [CSW-1:0] s1_f2;
  logic signed [CSW-1:0] s2_f1;
  logic                  s1pos1;
  logic                  s1pos2;
  logic                  c2z1;
  logic                  c2z2;
  logic signed [NUMW-1:0] num2;

  logic [NW-1:0] nf3;
  logic [DW-1:0] df3;
  logic          negf3;
  logic [NW-1:0] nl3;
  logic [DW-1:0] dl3;
  logic          negl3;
  flags_t        fl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
      vf2 <= 1'b0;
      vf3 <= 1'b0;
    end else if (en) begin
      vf1 <= vr1 & vr2;
      vf2 <= vf1;
      vf3 <= vf2;
    end
    if (en) begin
      p1     <= $signed({1'b0, camera_height}) * c1;
      den1   <= s1 * c2;
      s1_f1  <= s1;
      s2_f1  <= s2;
      s1pos1 <= s1 > 0;
      c2z1   <= c2 == '0;

      p2     <= p1;
      den2   <= den1;
      s1_f2  <= s1_f1;
      s1pos2 <= s1pos1;
      c2z2   <= c2z1;
      num2   <= NUMW'(p1 * s2_f1);

      nf3          <= p2[PW-1] ? NW'(-p2) : NW'(p2);
      df3          <= DW'($unsigned(s1_f2));
      negf3        <= p2[PW-1];
      nl3          <= num2[NUMW-1] ? NW'(-num2) : NW'(num2);
      dl3          <= den2[DNW-1] ? DW'(-den2) : DW'(den2);
      negl3        <= num2[NUMW-1] ^ den2[DNW-1];
      fl3.s1_pos   <= s1pos2;
      fl3.c2_zero  <= c2z2;
      fl3.num_zero <= num2 == '0;
      fl3.num_neg  <= num2[NUMW-1];
    end
  end

  // Forward and lateral divisions.
  logic              vd_f;
  logic              vd_l;
  pgp_pkg::div_res_t q_f;
  pgp_pkg::div_res_t q_l;

  pgp_div u_div_fwd (
    .clk(clk), .rst(rst), .en(en), .iv(vf3),
    .num(nf3), .den(df3), .neg(negf3), .ov(vd_f), .res(q_f)
  );

  pgp_div u_div_lat (
    .clk(clk), .rst(rst), .en(en), .iv(vf3),
    .num(nl3), .den(dl3), .neg(negl3), .ov(vd_l), .res(q_l)
  );

  // Special case flags travel alongside the dividers.
  flags_t fl [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= fl3;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_flags
    always_ff @(posedge clk) begin
      if (en) begin
        fl[k] <= fl[k-1];
      end
    end
  end

  // Saturate a signed quotient to 16 bits; bit 16 reports saturation.
  function automatic logic [16:0] sat_q(input pgp_pkg::div_res_t r);
    logic [16:0] o;
    if (r.ovf) begin
      o = r.neg ? {1'b1, 16'h8000} : {1'b1, 16'h7FFF};
    end else if (!r.neg) begin
      o = (r.q > QW'(32767)) ? {1'b1, 16'h7FFF} : {1'b0, r.q[15:0]};
    end else begin
      o = (r.q > QW'(32768)) ? {1'b1, 16'h8000} : {1'b0, 16'(-r.q[15:0])};
    end
    return o;
  endfunction

  logic [16:0] sf;
  logic [16:0] sl;
  flags_t      ff;

  assign sf = sat_q(q_f);
  assign sl = sat_q(q_l);
  assign ff = fl[DIV_LAT-1];

  // Output register and special cases.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd_f & vd_l;
    end
    if (en) begin
      if (!ff.s1_pos) begin
        ground_forward     <= 16'sh7FFF;
        ground_lateral     <= '0;
        projection_invalid <= 1'b1;
      end else if (ff.c2_zero) begin
        ground_forward     <= $signed(sf[15:0]);
        ground_lateral     <= ff.num_zero ? 16'sh0000 :
                              (ff.num_neg ? 16'sh8000 : 16'sh7FFF);
        projection_invalid <= sf[16] | ~ff.num_zero;
      end else begin
        ground_forward     <= $signed(sf[15:0]);
        ground_lateral     <= $signed(sl[15:0]);
        projection_invalid <= sf[16] | sl[16];
      end
    end
  end

endmodule
